FILE: sv/csvtok_pkg.sv
// ----------------------------------------------------------------------------
// csvtok_pkg
// Shared types and constants for the csv field tokenizer: character codes,
// token kinds, quote state and the per-item step result.
// ----------------------------------------------------------------------------
`default_nettype none

package csvtok_pkg;

    localparam int unsigned CHAR_W = 16;

    localparam logic [CHAR_W-1:0] CH_COMMA = 16'h002C;
    localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 16'h0022;

    // separator register codes
    localparam logic SEP_COMMA = 1'b0;
    localparam logic SEP_TAB   = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_ROW_END   = 2'd2
    } token_kind_t;

    typedef struct packed {
        logic in_quotes;
        logic quote_pending;
    } quote_state_t;

    typedef struct packed {
        logic              emit;
        token_kind_t       kind;
        logic [CHAR_W-1:0] out_char;
    } step_result_t;

endpackage

`default_nettype wire

FILE: sv/csvtok_step.sv
// ----------------------------------------------------------------------------
// csvtok_step
// Combinational decode of one item against the quote state: gives the token
// (if any) and the next quote state.
// ----------------------------------------------------------------------------
`default_nettype none

module csvtok_step (
    input  wire logic                            sep_mode,
    input  wire logic [csvtok_pkg::CHAR_W-1:0]   char_code,
    input  wire logic                            line_end,
    input  wire csvtok_pkg::quote_state_t        state_cur,
    output csvtok_pkg::quote_state_t             state_next,
    output csvtok_pkg::step_result_t             result
);

    logic [csvtok_pkg::CHAR_W-1:0] sep_char;
    logic                          is_quote;
    logic                          pend_literal;
    logic                          quoted;

    // separator select and quote classification
    assign sep_char     = (sep_mode == csvtok_pkg::SEP_TAB) ? csvtok_pkg::CH_TAB
                                                            : csvtok_pkg::CH_COMMA;
    assign is_quote     = (char_code == csvtok_pkg::CH_QUOTE);
    assign pend_literal = state_cur.quote_pending && !line_end && is_quote;
    // a pending quote followed by anything but a quote closes quoting first
    assign quoted       = state_cur.in_quotes &&
                          !(state_cur.quote_pending && !pend_literal);

    // token and next state
    always_comb
    begin
        state_next.in_quotes     = quoted;
        state_next.quote_pending = 1'b0;
        result.emit              = 1'b0;
        result.kind              = csvtok_pkg::KIND_DATA;
        result.out_char          = '0;
        priority if (pend_literal)
        begin
            state_next.in_quotes = 1'b1;
            result.emit          = 1'b1;
            result.out_char      = csvtok_pkg::CH_QUOTE;
        end
        else if (line_end)
        begin
            // line end inside quotes is dropped
            result.emit = !quoted;
            result.kind = csvtok_pkg::KIND_ROW_END;
        end
        else if (char_code == sep_char && !quoted)
        begin
            result.emit = 1'b1;
            result.kind = csvtok_pkg::KIND_FIELD_END;
        end
        else if (is_quote)
        begin
            if (quoted)
            begin
                state_next.quote_pending = 1'b1;
            end
            else
            begin
                state_next.in_quotes = 1'b1;
            end
        end
        else
        begin
            result.emit     = 1'b1;
            result.out_char = char_code;
        end
    end

endmodule

`default_nettype wire

FILE: sv/csv_field_tokenizer_core.sv
// Pipeline: an accepted item waits in the input register, is decoded
// combinationally, and its token, if any, is registered in the output register.
// Throughput: one item per cycle; the input register advances whenever the
// item gives no token or the output register is empty or being taken.
// Reset: rst_n asynchronous active low; clears both valid flags, the quote
// state (outside quotes, no pending quote) and selects comma as separator.
// ----------------------------------------------------------------------------
// csv_field_tokenizer_core
// Splits a stream of 16-bit code units into csv tokens with quote handling.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_tokenizer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: separator_mode
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] char_code
    input  wire logic        s_axis_tuser,   // [0] line_end
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] out_char
    output logic [1:0]       m_axis_tuser    // [1:0] token_kind
);

    logic                          sep_mode_reg;
    logic                          in_valid_reg;
    logic [csvtok_pkg::CHAR_W-1:0] in_char_reg;
    logic                          in_eol_reg;
    csvtok_pkg::quote_state_t      state_reg;
    csvtok_pkg::quote_state_t      state_next;
    csvtok_pkg::step_result_t      step_res;
    logic                          out_valid_reg;
    logic [csvtok_pkg::CHAR_W-1:0] out_char_reg;
    csvtok_pkg::token_kind_t       out_kind_reg;
    logic                          advance;

    // separator register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_mode_reg <= csvtok_pkg::SEP_COMMA;
        end
        else if (cfg_we)
        begin
            sep_mode_reg <= cfg_wdata;
        end
    end

    // item decode
    csvtok_step u_step (
        .sep_mode   (sep_mode_reg),
        .char_code  (in_char_reg),
        .line_end   (in_eol_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (step_res)
    );

    // the held item moves on when it needs no output slot or the slot frees up
    assign advance       = in_valid_reg &&
                           (!step_res.emit || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_eol_reg  <= s_axis_tuser;
        end
    end

    // quote state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && step_res.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_res.emit)
        begin
            out_char_reg <= step_res.out_char;
            out_kind_reg <= step_res.kind;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tuser  = out_kind_reg;

endmodule

`default_nettype wire

FILE: sv/csvtok_checker.sv
// ----------------------------------------------------------------------------
// csvtok_checker
// Port-level checks on the tokenizer output and flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module csvtok_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // only the three token kinds appear
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == csvtok_pkg::KIND_DATA ||
                           m_axis_tuser == csvtok_pkg::KIND_FIELD_END ||
                           m_axis_tuser == csvtok_pkg::KIND_ROW_END))
        else $error("illegal token kind");

    // field and row ends carry no character
    a_end_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != csvtok_pkg::KIND_DATA) |->
            (m_axis_tdata == 16'h0000))
        else $error("end token with nonzero character");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled output changed");

endmodule

bind csv_field_tokenizer_core csvtok_checker u_csvtok_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
